// ----- rtl/rccb_pkg.sv -----
// Shared widths, register indexes, generator constants and sequencer states of the chase builder.
`default_nettype none

package rccb_pkg;

   localparam int NODE_W        = 12;
   localparam int COUNT_W       = 13;
   localparam int SEED_W        = 32;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int MAX_NODES_DEF = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUFFLE_SEED = 2'd1;

   localparam logic ACT_BUILD  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
   localparam logic [SEED_W-1:0]  SEED_RESET  = 32'hdeadbeef;
   localparam logic [SEED_W-1:0]  LCG_MUL     = 32'd1664525;
   localparam logic [SEED_W-1:0]  LCG_ADD     = 32'd1013904223;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_FILL,
      ST_SHUF_LCG,
      ST_SHUF_DIV,
      ST_SHUF_RD,
      ST_SHUF_WI,
      ST_SHUF_WJ,
      ST_LINK_START,
      ST_LINK_FIRST,
      ST_LINK_RUN,
      ST_LINK_LAST,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/rccb_mod_unit.sv -----
// Bit-serial restoring remainder unit that reduces the generator value modulo the swap range.
`default_nettype none

module rccb_mod_unit #(
   parameter int DIV_W = 13
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rccb_pkg::SEED_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]            divisor,
   output logic                             done,
   output logic [DIV_W-1:0]                 remainder
);

   localparam int STEP_W = $clog2(rccb_pkg::SEED_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(rccb_pkg::SEED_W - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [rccb_pkg::SEED_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]            rem_ff, rem_in;
   logic [DIV_W-1:0]            dvs_ff, dvs_in;
   logic [DIV_W:0]              rem_sh;
   logic [DIV_W:0]              diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[rccb_pkg::SEED_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[rccb_pkg::SEED_W-2:0], 1'b0};
         rem_in  = diff[DIV_W] ? rem_sh[DIV_W-1:0] : diff[DIV_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/random_cyclic_chase_builder.sv -----
// Top level of the chase builder: sequencer, permutation and successor memories, result register.
`default_nettype none

// A lookup transfer reads the successor memory once into a read register, from which the result
// register is loaded once it is free. A build transfer fills the permutation memory with the
// identity (one entry a cycle), then shuffles it from the top index down, each step running the
// generator, the bit-serial remainder unit (one bit of the 32-bit generator value per cycle), a
// read and two writes, and finally links the cycle into the successor memory at one entry a
// cycle. The block takes one request at a time; a new request is accepted in the cycle after
// the previous one has reached the result register, and a finished request waits while an
// earlier result is still held there.
module random_cyclic_chase_builder #(
   parameter int MAX_NODES = rccb_pkg::MAX_NODES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_action,
   input  wire logic [rccb_pkg::NODE_W-1:0]     req_node_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [rccb_pkg::NODE_W-1:0]          rsp_head_node,
   output logic [rccb_pkg::NODE_W-1:0]          rsp_next_node,
   input  wire logic                            csr_we,
   input  wire logic [rccb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rccb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int NW = (CW > rccb_pkg::COUNT_W) ? CW : rccb_pkg::COUNT_W;

   rccb_pkg::state_type state_ff, state_in;

   logic [rccb_pkg::COUNT_W-1:0] node_count_ff;
   logic [rccb_pkg::SEED_W-1:0]  seed_ff;
   logic [rccb_pkg::SEED_W-1:0]  lcg_ff, lcg_in;
   logic [AW-1:0]                head_ff, head_in;
   logic [CW-1:0]                built_ff, built_in;
   logic [CW-1:0]                n_ff, n_in;
   logic [AW-1:0]                fill_ff, fill_in;
   logic [AW-1:0]                shuf_i_ff, shuf_i_in;
   logic [AW-1:0]                shuf_j_ff, shuf_j_in;
   logic [AW-1:0]                link_k_ff, link_k_in;
   logic [AW-1:0]                prev_ff, prev_in;
   logic                         hit_ff, hit_in;
   logic                         rsp_valid_ff;
   logic [rccb_pkg::NODE_W-1:0]  rsp_head_ff, rsp_head_in;
   logic [rccb_pkg::NODE_W-1:0]  rsp_next_ff, rsp_next_in;

   logic [AW-1:0] perm_mem [MAX_NODES];
   logic [AW-1:0] succ_mem [MAX_NODES];
   logic [AW-1:0] perm_rd_a_ff, perm_rd_b_ff, succ_rd_ff;

   logic          perm_we, perm_re, succ_we, succ_re;
   logic [AW-1:0] perm_waddr, perm_wdata, perm_raddr_a, perm_raddr_b;
   logic [AW-1:0] succ_waddr, succ_wdata, succ_raddr;

   logic                        div_start, div_done;
   logic [rccb_pkg::SEED_W-1:0] div_dividend;
   logic [CW-1:0]               div_divisor, div_rem;

   logic          out_free, load_rsp;
   logic          fill_last, link_last, lookup_hit;
   logic [NW-1:0] count_ext, active_ext, index_ext;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_ext = NW'(node_count_ff);
      if (count_ext == '0) begin
         active_ext = NW'(1);
      end else if (count_ext > NW'(MAX_NODES)) begin
         active_ext = NW'(MAX_NODES);
      end else begin
         active_ext = count_ext;
      end
   end

   assign index_ext  = NW'(req_node_index);
   assign lookup_hit = index_ext < NW'(built_ff);
   assign fill_last  = (CW'(fill_ff) + CW'(1)) == n_ff;
   assign link_last  = (CW'(link_k_ff) + CW'(1)) == n_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rccb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_action == rccb_pkg::ACT_BUILD) ? rccb_pkg::ST_FILL
                                                              : rccb_pkg::ST_LOOKUP;
            end
         end
         rccb_pkg::ST_LOOKUP: begin
            if (out_free) state_in = rccb_pkg::ST_IDLE;
         end
         rccb_pkg::ST_FILL: begin
            if (fill_last) begin
               state_in = (n_ff == CW'(1)) ? rccb_pkg::ST_LINK_START : rccb_pkg::ST_SHUF_LCG;
            end
         end
         rccb_pkg::ST_SHUF_LCG: state_in = rccb_pkg::ST_SHUF_DIV;
         rccb_pkg::ST_SHUF_DIV: begin
            if (div_done) state_in = rccb_pkg::ST_SHUF_RD;
         end
         rccb_pkg::ST_SHUF_RD:  state_in = rccb_pkg::ST_SHUF_WI;
         rccb_pkg::ST_SHUF_WI:  state_in = rccb_pkg::ST_SHUF_WJ;
         rccb_pkg::ST_SHUF_WJ: begin
            state_in = (shuf_i_ff == AW'(1)) ? rccb_pkg::ST_LINK_START : rccb_pkg::ST_SHUF_LCG;
         end
         rccb_pkg::ST_LINK_START: state_in = rccb_pkg::ST_LINK_FIRST;
         rccb_pkg::ST_LINK_FIRST: begin
            state_in = (n_ff == CW'(1)) ? rccb_pkg::ST_LINK_LAST : rccb_pkg::ST_LINK_RUN;
         end
         rccb_pkg::ST_LINK_RUN: begin
            if (link_last) state_in = rccb_pkg::ST_LINK_LAST;
         end
         rccb_pkg::ST_LINK_LAST: state_in = rccb_pkg::ST_DONE;
         rccb_pkg::ST_DONE: begin
            if (out_free) state_in = rccb_pkg::ST_IDLE;
         end
         default: state_in = rccb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      lcg_in       = lcg_ff;
      head_in      = head_ff;
      built_in     = built_ff;
      n_in         = n_ff;
      fill_in      = fill_ff;
      shuf_i_in    = shuf_i_ff;
      shuf_j_in    = shuf_j_ff;
      link_k_in    = link_k_ff;
      prev_in      = prev_ff;
      hit_in       = hit_ff;
      perm_we      = 1'b0;
      perm_waddr   = fill_ff;
      perm_wdata   = fill_ff;
      perm_re      = 1'b0;
      perm_raddr_a = shuf_i_ff;
      perm_raddr_b = shuf_j_ff;
      succ_we      = 1'b0;
      succ_waddr   = prev_ff;
      succ_wdata   = perm_rd_a_ff;
      succ_re      = 1'b0;
      succ_raddr   = index_ext[AW-1:0];
      div_start    = 1'b0;
      div_dividend = lcg_ff;
      div_divisor  = CW'(shuf_i_ff) + CW'(1);
      load_rsp     = 1'b0;
      rsp_head_in  = rccb_pkg::NODE_W'(head_ff);
      rsp_next_in  = rccb_pkg::NODE_W'(head_ff);
      case (state_ff)
         rccb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == rccb_pkg::ACT_BUILD) begin
                  n_in    = CW'(active_ext);
                  fill_in = '0;
                  lcg_in  = seed_ff;
               end else begin
                  succ_re = 1'b1;
                  hit_in  = lookup_hit;
               end
            end
         end
         rccb_pkg::ST_LOOKUP: begin
            load_rsp    = out_free;
            rsp_next_in = hit_ff ? rccb_pkg::NODE_W'(succ_rd_ff) : '0;
         end
         rccb_pkg::ST_FILL: begin
            perm_we = 1'b1;
            fill_in = fill_ff + AW'(1);
            if (fill_last) shuf_i_in = AW'(n_ff - CW'(1));
         end
         rccb_pkg::ST_SHUF_LCG: begin
            lcg_in       = lcg_ff * rccb_pkg::LCG_MUL + rccb_pkg::LCG_ADD;
            div_start    = 1'b1;
            div_dividend = lcg_in;
         end
         rccb_pkg::ST_SHUF_DIV: begin
            if (div_done) shuf_j_in = div_rem[AW-1:0];
         end
         rccb_pkg::ST_SHUF_RD: begin
            perm_re = 1'b1;
         end
         rccb_pkg::ST_SHUF_WI: begin
            perm_we    = 1'b1;
            perm_waddr = shuf_i_ff;
            perm_wdata = perm_rd_b_ff;
         end
         rccb_pkg::ST_SHUF_WJ: begin
            perm_we    = 1'b1;
            perm_waddr = shuf_j_ff;
            perm_wdata = perm_rd_a_ff;
            shuf_i_in  = shuf_i_ff - AW'(1);
         end
         rccb_pkg::ST_LINK_START: begin
            perm_re      = 1'b1;
            perm_raddr_a = '0;
         end
         rccb_pkg::ST_LINK_FIRST: begin
            head_in = perm_rd_a_ff;
            prev_in = perm_rd_a_ff;
            if (n_ff != CW'(1)) begin
               perm_re      = 1'b1;
               perm_raddr_a = AW'(1);
               link_k_in    = AW'(1);
            end
         end
         rccb_pkg::ST_LINK_RUN: begin
            succ_we = 1'b1;
            prev_in = perm_rd_a_ff;
            if (!link_last) begin
               perm_re      = 1'b1;
               perm_raddr_a = link_k_ff + AW'(1);
               link_k_in    = link_k_ff + AW'(1);
            end
         end
         rccb_pkg::ST_LINK_LAST: begin
            succ_we    = 1'b1;
            succ_wdata = head_ff;
            built_in   = n_ff;
         end
         rccb_pkg::ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   rccb_mod_unit #(
      .DIV_W(CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
      if (perm_re) begin
         perm_rd_a_ff <= perm_mem[perm_raddr_a];
         perm_rd_b_ff <= perm_mem[perm_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (succ_we) succ_mem[succ_waddr] <= succ_wdata;
      if (succ_re) succ_rd_ff <= succ_mem[succ_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rccb_pkg::ST_IDLE;
         node_count_ff <= rccb_pkg::COUNT_RESET;
         seed_ff       <= rccb_pkg::SEED_RESET;
         lcg_ff        <= rccb_pkg::SEED_RESET;
         head_ff       <= '0;
         built_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         lcg_ff   <= lcg_in;
         head_ff  <= head_in;
         built_ff <= built_in;
         if (csr_we && csr_index == rccb_pkg::CSR_NODE_COUNT) begin
            node_count_ff <= csr_wdata[rccb_pkg::COUNT_W-1:0];
         end
         if (csr_we && csr_index == rccb_pkg::CSR_SHUFFLE_SEED) begin
            seed_ff <= csr_wdata[rccb_pkg::SEED_W-1:0];
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      n_ff      <= n_in;
      fill_ff   <= fill_in;
      shuf_i_ff <= shuf_i_in;
      shuf_j_ff <= shuf_j_in;
      link_k_ff <= link_k_in;
      prev_ff   <= prev_in;
      hit_ff    <= hit_in;
      if (load_rsp) begin
         rsp_head_ff <= rsp_head_in;
         rsp_next_ff <= rsp_next_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_head_node = rsp_head_ff;
   assign rsp_next_node = rsp_next_ff;

endmodule

`default_nettype wire

// ----- rtl/rccb_checker.sv -----
// Port-level checker for the chase builder and the bind that attaches it to the top level.
`default_nettype none

module rccb_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [rccb_pkg::NODE_W-1:0] rsp_head_node,
   input wire logic [rccb_pkg::NODE_W-1:0] rsp_next_node
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_head_node) && $stable(rsp_next_node))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a request in progress");

endmodule

bind random_cyclic_chase_builder rccb_checker u_rccb_checker (.*);

`default_nettype wire

// ----- tb/sv/random_cyclic_chase_builder_tb.sv -----
// Self-checking testbench for the shuffled pointer-chase successor table builder.
`timescale 1ns / 100ps

module random_cyclic_chase_builder_tb;

   localparam int          TABLE_DEPTH  = rccb_pkg::MAX_NODES_DEF;
   localparam int unsigned RANDOM_ITEMS = 1230;
   localparam int unsigned QUIET_AFTER  = 1100;
   localparam longint      CYCLE_LIMIT  = 10000000;

   localparam logic [rccb_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [rccb_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [rccb_pkg::NODE_W-1:0] head;
      logic [rccb_pkg::NODE_W-1:0] next;
   } chase_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_action = rccb_pkg::ACT_LOOKUP;
   logic [rccb_pkg::NODE_W-1:0]     req_node_index = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [rccb_pkg::NODE_W-1:0]     rsp_head_node;
   logic [rccb_pkg::NODE_W-1:0]     rsp_next_node;
   logic                            csr_we = 1'b0;
   logic [rccb_pkg::CSR_IDX_W-1:0]  csr_index = rccb_pkg::CSR_NODE_COUNT;
   logic [rccb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the block's configuration and tables.
   logic [rccb_pkg::COUNT_W-1:0] cfg_count = rccb_pkg::COUNT_RESET;
   logic [rccb_pkg::SEED_W-1:0]  cfg_seed = rccb_pkg::SEED_RESET;
   logic [rccb_pkg::NODE_W-1:0]  perm_mem [TABLE_DEPTH];
   logic [rccb_pkg::NODE_W-1:0]  succ_mem [TABLE_DEPTH];
   logic [rccb_pkg::NODE_W-1:0]  model_head = '0;
   int unsigned                  built_nodes = 0;

   chase_result_type   pending_results [$];
   chase_result_type   oldest;
   int unsigned        error_count = 0;
   int unsigned        items_sent = 0;
   int unsigned        builds_sent = 0;
   int unsigned        results_checked = 0;
   int unsigned        csr_writes = 0;
   longint             cycle_count = 0;
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_idle_pct = 0;
   int unsigned        hold_cycles = 0;

   random_cyclic_chase_builder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_node_index (req_node_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_head_node  (rsp_head_node),
      .rsp_next_node  (rsp_next_node),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
         $display("FAIL random_cyclic_chase_builder");
         $finish;
      end
   end

   function automatic void shuffle_and_link();
      int unsigned n;
      int unsigned i;
      int unsigned j;
      logic [rccb_pkg::SEED_W-1:0] x;
      logic [rccb_pkg::NODE_W-1:0] t;
      n = cfg_count;
      if (n < 1) n = 1;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      x = cfg_seed;
      for (i = 0; i < n; i++) perm_mem[i] = i[rccb_pkg::NODE_W-1:0];
      for (i = n - 1; i > 0; i--) begin
         x = x * rccb_pkg::LCG_MUL + rccb_pkg::LCG_ADD;
         j = x % (i + 1);
         t = perm_mem[i];
         perm_mem[i] = perm_mem[j];
         perm_mem[j] = t;
      end
      for (i = 0; i + 1 < n; i++) succ_mem[perm_mem[i]] = perm_mem[i + 1];
      succ_mem[perm_mem[n - 1]] = perm_mem[0];
      model_head = perm_mem[0];
      built_nodes = n;
   endfunction

   function automatic chase_result_type predict_chase(logic act,
                                                      logic [rccb_pkg::NODE_W-1:0] idx);
      chase_result_type r;
      if (act == rccb_pkg::ACT_BUILD) begin
         shuffle_and_link();
         r.next = model_head;
      end else if (idx < built_nodes) begin
         r.next = succ_mem[idx];
      end else begin
         r.next = '0;
      end
      r.head = model_head;
      return r;
   endfunction

   function automatic int unsigned pick_idle_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 60;
      endcase
   endfunction

   task automatic send_item(input logic act, input logic [rccb_pkg::NODE_W-1:0] idx);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_node_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_chase(act, idx));
      items_sent++;
      if (act == rccb_pkg::ACT_BUILD) builds_sent++;
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_reg(input logic [rccb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rccb_pkg::CSR_DATA_W-1:0] data);
      wait_results_done();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rccb_pkg::CSR_NODE_COUNT) cfg_count = data[rccb_pkg::COUNT_W-1:0];
      else if (idx == rccb_pkg::CSR_SHUFFLE_SEED) cfg_seed = data;
      csr_writes++;
      @(posedge clock);
   endtask

   initial begin : rsp_side
      int unsigned len;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            len = hold_cycles;
            hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (len - 1) @(posedge clock);
         end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result head=%0d next=%0d", $time, rsp_head_node,
                     rsp_next_node);
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            results_checked++;
            if (rsp_head_node !== oldest.head) begin
               $display("%0t: head_node mismatch expected=%0d actual=%0d", $time, oldest.head,
                        rsp_head_node);
               error_count++;
            end
            if (rsp_next_node !== oldest.next) begin
               $display("%0t: next_node mismatch expected=%0d actual=%0d", $time, oldest.next,
                        rsp_next_node);
               error_count++;
            end
         end
      end
   end

   // The table is still empty, so every lookup answers zero.
   task automatic test_lookup_before_build();
      send_item(rccb_pkg::ACT_LOOKUP, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, 12'hfff);
   endtask

   task automatic test_reset_config_build();
      send_item(rccb_pkg::ACT_BUILD, 12'hfff);
      send_item(rccb_pkg::ACT_LOOKUP, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, 12'hfff);
      send_item(rccb_pkg::ACT_LOOKUP, model_head);
   endtask

   task automatic test_count_extremes();
      write_reg(rccb_pkg::CSR_NODE_COUNT, 32'd0);
      send_item(rccb_pkg::ACT_BUILD, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, 12'd1);
      write_reg(rccb_pkg::CSR_NODE_COUNT, 32'd1);
      send_item(rccb_pkg::ACT_BUILD, 12'd5);
      send_item(rccb_pkg::ACT_LOOKUP, 12'd0);
      write_reg(rccb_pkg::CSR_NODE_COUNT, 32'd2);
      send_item(rccb_pkg::ACT_BUILD, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, 12'd1);
      write_reg(rccb_pkg::CSR_NODE_COUNT, 32'h0000_1fff);
      send_item(rccb_pkg::ACT_BUILD, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, 12'hfff);
   endtask

   task automatic test_seed_extremes();
      write_reg(rccb_pkg::CSR_NODE_COUNT, 32'd16);
      write_reg(rccb_pkg::CSR_SHUFFLE_SEED, 32'h0000_0000);
      send_item(rccb_pkg::ACT_BUILD, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, model_head);
      write_reg(rccb_pkg::CSR_SHUFFLE_SEED, 32'hffff_ffff);
      send_item(rccb_pkg::ACT_BUILD, 12'hfff);
      send_item(rccb_pkg::ACT_LOOKUP, 12'd15);
   endtask

   // Writes to the spare indexes must leave both registers as they were.
   task automatic test_spare_registers();
      write_reg(CSR_SPARE_2, 32'd3);
      write_reg(CSR_SPARE_3, 32'h1234_5678);
      send_item(rccb_pkg::ACT_BUILD, 12'd0);
      send_item(rccb_pkg::ACT_LOOKUP, 12'd16);
   endtask

   task automatic test_result_backpressure();
      int unsigned k;
      write_reg(rccb_pkg::CSR_NODE_COUNT, 32'd8);
      send_item(rccb_pkg::ACT_BUILD, 12'd0);
      send_idle_pct = 0;
      hold_cycles = 300;
      for (k = 0; k < 8; k++) send_item(rccb_pkg::ACT_LOOKUP, k[rccb_pkg::NODE_W-1:0]);
      wait_results_done();
   endtask

   task automatic test_random_phases();
      int unsigned start_items;
      int unsigned n;
      int unsigned steps;
      int unsigned k;
      int unsigned pick;
      logic [rccb_pkg::NODE_W-1:0] node;
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         if (items_sent - start_items > QUIET_AFTER) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = pick_idle_pct();
            recv_idle_pct = pick_idle_pct();
         end
         pick = $urandom_range(0, 15);
         if (pick < 10) n = $urandom_range(1, 12);
         else if (pick < 14) n = $urandom_range(13, 64);
         else if (pick == 14) n = $urandom_range(65, 300);
         else n = 0;
         write_reg(rccb_pkg::CSR_NODE_COUNT, ($urandom() & 32'hffff_e000) | n);
         if ($urandom_range(0, 3) != 0) write_reg(rccb_pkg::CSR_SHUFFLE_SEED, $urandom());
         if ($urandom_range(0, 7) == 0) begin
            write_reg(CSR_SPARE_2 | rccb_pkg::CSR_IDX_W'($urandom_range(0, 1)), $urandom());
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(rccb_pkg::ACT_LOOKUP, rccb_pkg::NODE_W'($urandom_range(0, 4095)));
         end
         send_item(rccb_pkg::ACT_BUILD, rccb_pkg::NODE_W'($urandom_range(0, 4095)));
         node = model_head;
         steps = $urandom_range(8, 30);
         for (k = 0; k < steps; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               send_item(rccb_pkg::ACT_LOOKUP, node);
               node = succ_mem[node];
            end else if (pick < 8) begin
               send_item(rccb_pkg::ACT_LOOKUP,
                         rccb_pkg::NODE_W'($urandom_range(0, built_nodes - 1)));
            end else if (pick == 8) begin
               send_item(rccb_pkg::ACT_LOOKUP, rccb_pkg::NODE_W'($urandom_range(0, 4095)));
            end else begin
               send_item(rccb_pkg::ACT_BUILD, rccb_pkg::NODE_W'($urandom_range(0, 4095)));
               node = model_head;
            end
         end
      end
   endtask

   initial begin
      wait (!reset);
      @(posedge clock);
      test_lookup_before_build();
      test_reset_config_build();
      send_idle_pct = 30;
      recv_idle_pct = 30;
      test_count_extremes();
      test_seed_extremes();
      test_spare_registers();
      test_result_backpressure();
      test_random_phases();
      wait_results_done();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests (%0d builds) over %0d register writes; %0d results checked.",
               items_sent, builds_sent, csr_writes, results_checked);
      $display("Included empty-table, single-node, clamped-count and out-of-range lookups.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS random_cyclic_chase_builder");
      end else begin
         $display("FAIL random_cyclic_chase_builder");
      end
      $finish;
   end

endmodule
